// ===== rtl/core/lpc_pkg.sv =====
// Types and constants shared by the layer pixel compositor and its checker.
package lpc_pkg;

    localparam int unsigned LUT_DEPTH = 256;
    localparam int unsigned CH_COUNT  = 3;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_BLEND_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAYER_ALPHA   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EFFECT_SELECT = 2'd2;

    localparam logic OP_BLEND     = 1'b0;
    localparam logic OP_LUT_WRITE = 1'b1;

    localparam logic BLEND_ALPHA    = 1'b0;
    localparam logic BLEND_ADDITIVE = 1'b1;

    localparam logic [1:0] EFFECT_NONE  = 2'd0;
    localparam logic [1:0] EFFECT_GRAY  = 2'd1;
    localparam logic [1:0] EFFECT_SEPIA = 2'd2;

    localparam logic [8:0] ALPHA_ONE   = 9'd256;
    localparam logic [7:0] CH_MAX      = 8'd255;

    // Division by three of a sum of three channels: (s * 683) >> 11 is exact up to 765.
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int unsigned GRAY_SHIFT = 11;

    localparam int unsigned Q12_SHIFT = 12;

    localparam logic [11:0] SEPIA_Q12 [CH_COUNT][CH_COUNT] = '{
        '{12'd1610, 12'd3150, 12'd774},
        '{12'd1430, 12'd2810, 12'd688},
        '{12'd1114, 12'd2187, 12'd537}
    };

    typedef struct packed {
        logic       op;
        logic [7:0] acc_red;
        logic [7:0] acc_green;
        logic [7:0] acc_blue;
        logic [7:0] layer_red;
        logic [7:0] layer_green;
        logic [7:0] layer_blue;
        logic [7:0] table_index;
        logic [7:0] table_value;
    } in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_t;

endpackage

// ===== rtl/core/layer_pixel_compositor.sv =====
// Layer pixel compositor: effect, tone look-up and blend of one layer pixel per beat.
//
// The block takes one beat per clock cycle while src_stall is low and offers one blended pixel
// per accepted pixel beat; a look-up write beat produces no result. Four pipeline stages
// (input register, effect, look-up read, output register) each hold one beat, and a stage
// moves up as soon as the stage after it empties, so a stalled result does not halt the
// input until the pipeline is full. The tone look-up table is held in three copies, one per
// colour channel, each read once and written once per cycle in the same stage, so a write
// beat takes effect for every pixel beat accepted after it. After reset the table reads as
// the identity mapping through one valid bit per entry; there is no clearing pass.
module layer_pixel_compositor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [lpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  lpc_pkg::in_t                        src_data,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output lpc_pkg::out_t                       dst_data
);

    logic       blend_mode_reg;
    logic [8:0] layer_alpha_reg;
    logic [1:0] effect_select_reg;

    logic         a_valid_reg;
    logic         a_valid_next;
    lpc_pkg::in_t a_item_reg;

    logic       b_valid_reg;
    logic       b_valid_next;
    logic       b_wr_reg;
    logic [7:0] b_idx_reg;
    logic [7:0] b_val_reg;
    logic [7:0] b_acc_reg [lpc_pkg::CH_COUNT];
    logic [7:0] b_px_reg  [lpc_pkg::CH_COUNT];

    logic       c_valid_reg;
    logic       c_valid_next;
    logic       c_wr_reg;
    logic [7:0] c_acc_reg [lpc_pkg::CH_COUNT];
    logic [7:0] c_px_reg  [lpc_pkg::CH_COUNT];
    logic [7:0] c_lut_reg [lpc_pkg::CH_COUNT];
    logic       c_hit_reg [lpc_pkg::CH_COUNT];

    logic          dst_valid_reg;
    logic          dst_valid_next;
    lpc_pkg::out_t dst_data_reg;

    logic [7:0] lut_mem [lpc_pkg::CH_COUNT][lpc_pkg::LUT_DEPTH];
    logic [lpc_pkg::LUT_DEPTH-1:0] lut_vld_reg;

    logic o_free;
    logic c_free;
    logic b_free;
    logic a_free;

    logic [7:0]  lay      [lpc_pkg::CH_COUNT];
    logic [7:0]  acc_in   [lpc_pkg::CH_COUNT];
    logic [9:0]  gray_sum;
    logic [19:0] gray_prod;
    logic [7:0]  gray_val;
    logic [20:0] sep_sum  [lpc_pkg::CH_COUNT];
    logic [8:0]  sep_shr  [lpc_pkg::CH_COUNT];
    logic [7:0]  sep_val  [lpc_pkg::CH_COUNT];
    logic [7:0]  fx_val   [lpc_pkg::CH_COUNT];

    logic [8:0]  alpha_eff;
    logic [8:0]  alpha_inv;
    logic [7:0]  lut_out  [lpc_pkg::CH_COUNT];
    logic [16:0] mix_sum  [lpc_pkg::CH_COUNT];
    logic [16:0] add_prod [lpc_pkg::CH_COUNT];
    logic [8:0]  add_sum  [lpc_pkg::CH_COUNT];
    logic [7:0]  blend_val [lpc_pkg::CH_COUNT];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg    <= lpc_pkg::BLEND_ALPHA;
            layer_alpha_reg   <= lpc_pkg::ALPHA_ONE;
            effect_select_reg <= lpc_pkg::EFFECT_NONE;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                lpc_pkg::CFG_BLEND_MODE:    blend_mode_reg    <= cfg_data[0];
                lpc_pkg::CFG_LAYER_ALPHA:   layer_alpha_reg   <= cfg_data[8:0];
                lpc_pkg::CFG_EFFECT_SELECT: effect_select_reg <= cfg_data[1:0];
                default:                    ;
            endcase
        end
    end

    // Stage flow: a stage may load when it is empty or its beat moves on.
    always_comb
    begin
        o_free = !dst_valid_reg || !dst_stall;
        c_free = !c_valid_reg || c_wr_reg || o_free;
        b_free = !b_valid_reg || c_free;
        a_free = !a_valid_reg || b_free;

        src_stall      = !a_free;
        a_valid_next   = a_free ? src_valid : a_valid_reg;
        b_valid_next   = b_free ? a_valid_reg : b_valid_reg;
        c_valid_next   = c_free ? b_valid_reg : c_valid_reg;
        dst_valid_next = o_free ? (c_valid_reg && !c_wr_reg) : dst_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_item_reg <= src_data;
        end
    end

    // Effect stage: grayscale mean, sepia matrix or pass-through.
    always_comb
    begin
        lay[0]    = a_item_reg.layer_red;
        lay[1]    = a_item_reg.layer_green;
        lay[2]    = a_item_reg.layer_blue;
        acc_in[0] = a_item_reg.acc_red;
        acc_in[1] = a_item_reg.acc_green;
        acc_in[2] = a_item_reg.acc_blue;

        gray_sum  = 10'(lay[0]) + 10'(lay[1]) + 10'(lay[2]);
        gray_prod = 20'(gray_sum) * 20'(lpc_pkg::GRAY_RECIP);
        gray_val  = gray_prod[lpc_pkg::GRAY_SHIFT +: 8];

        for (int k = 0; k < lpc_pkg::CH_COUNT; k++)
        begin
            sep_sum[k] = 21'(lpc_pkg::SEPIA_Q12[k][0]) * 21'(lay[0])
                       + 21'(lpc_pkg::SEPIA_Q12[k][1]) * 21'(lay[1])
                       + 21'(lpc_pkg::SEPIA_Q12[k][2]) * 21'(lay[2]);
            sep_shr[k] = sep_sum[k][lpc_pkg::Q12_SHIFT +: 9];
            sep_val[k] = (sep_shr[k] > 9'(lpc_pkg::CH_MAX)) ? lpc_pkg::CH_MAX : sep_shr[k][7:0];
        end

        for (int k = 0; k < lpc_pkg::CH_COUNT; k++)
        begin
            case (effect_select_reg)
                lpc_pkg::EFFECT_GRAY:  fx_val[k] = gray_val;
                lpc_pkg::EFFECT_SEPIA: fx_val[k] = sep_val[k];
                default:               fx_val[k] = lay[k];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free)
        begin
            b_wr_reg  <= (a_item_reg.op == lpc_pkg::OP_LUT_WRITE);
            b_idx_reg <= a_item_reg.table_index;
            b_val_reg <= a_item_reg.table_value;
            for (int k = 0; k < lpc_pkg::CH_COUNT; k++)
            begin
                b_acc_reg[k] <= acc_in[k];
                b_px_reg[k]  <= fx_val[k];
            end
        end
    end

    // Look-up stage: writes and reads of the table happen here in beat order.
    always_ff @(posedge clk)
    begin
        if (c_free)
        begin
            c_wr_reg <= b_wr_reg;
            for (int k = 0; k < lpc_pkg::CH_COUNT; k++)
            begin
                if (b_valid_reg && b_wr_reg)
                begin
                    lut_mem[k][b_idx_reg] <= b_val_reg;
                end
                c_lut_reg[k] <= lut_mem[k][b_px_reg[k]];
                c_hit_reg[k] <= lut_vld_reg[b_px_reg[k]];
                c_acc_reg[k] <= b_acc_reg[k];
                c_px_reg[k]  <= b_px_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_vld_reg <= '0;
        end
        else if (c_free && b_valid_reg && b_wr_reg)
        begin
            lut_vld_reg[b_idx_reg] <= 1'b1;
        end
    end

    // Blend stage into the output register.
    always_comb
    begin
        alpha_eff = (layer_alpha_reg > lpc_pkg::ALPHA_ONE) ? lpc_pkg::ALPHA_ONE : layer_alpha_reg;
        alpha_inv = lpc_pkg::ALPHA_ONE - alpha_eff;
        for (int k = 0; k < lpc_pkg::CH_COUNT; k++)
        begin
            lut_out[k]  = c_hit_reg[k] ? c_lut_reg[k] : c_px_reg[k];
            add_prod[k] = 17'(lut_out[k]) * 17'(alpha_eff);
            mix_sum[k]  = 17'(c_acc_reg[k]) * 17'(alpha_inv) + add_prod[k];
            add_sum[k]  = 9'(c_acc_reg[k]) + 9'(add_prod[k][15:8]);
            if (blend_mode_reg == lpc_pkg::BLEND_ADDITIVE)
            begin
                blend_val[k] = (add_sum[k] > 9'(lpc_pkg::CH_MAX)) ? lpc_pkg::CH_MAX
                                                                 : add_sum[k][7:0];
            end
            else
            begin
                blend_val[k] = mix_sum[k][15:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_free)
        begin
            dst_data_reg.out_red   <= blend_val[0];
            dst_data_reg.out_green <= blend_val[1];
            dst_data_reg.out_blue  <= blend_val[2];
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

// ===== rtl/core/lpc_checker.sv =====
// Port-level checker for the layer pixel compositor, bound to the compositor module.
module lpc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          src_valid,
    input logic          src_stall,
    input lpc_pkg::in_t  src_data,
    input logic          dst_valid,
    input logic          dst_stall,
    input lpc_pkg::out_t dst_data
);

    localparam logic [3:0] PIPE_DEPTH = 4'd4;

    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       px_beat;
    logic       out_beat;

    always_comb
    begin
        px_beat   = src_valid && !src_stall && (src_data.op == lpc_pkg::OP_BLEND);
        out_beat  = dst_valid && !dst_stall;
        pend_next = pend_reg + 4'(px_beat) - 4'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid)
        else $error("Result beat withdrawn while stalled.");

    // A stalled result keeps its pixel.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> $stable(dst_data))
        else $error("Result beat changed while stalled.");

    // Every result belongs to a pixel beat that is still outstanding.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> pend_reg != 4'd0)
        else $error("Result beat without an outstanding pixel beat.");

    // The pipeline never holds more pixel beats than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PIPE_DEPTH)
        else $error("More pixel beats outstanding than pipeline stages.");

endmodule

bind layer_pixel_compositor lpc_checker u_lpc_checker (.*);

// ===== tb/tb_layer_pixel_compositor.sv =====
// Self-checking testbench for the layer pixel compositor: directed, random and back-pressure tests.
module tb_layer_pixel_compositor;
    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE    = 2'd3;
    localparam logic [1:0]            EFFECT_SPARE = 2'd3;
    localparam int unsigned           SETTLE_CYCLES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  src_valid = 1'b0;
    logic                  src_stall;
    in_t                   src_data  = '0;
    logic                  dst_valid;
    logic                  dst_stall = 1'b0;
    out_t                  dst_data;

    logic [7:0] tone_lut [LUT_DEPTH];
    logic       cur_blend  = BLEND_ALPHA;
    logic [8:0] cur_alpha  = ALPHA_ONE;
    logic [1:0] cur_effect = EFFECT_NONE;

    out_t expected_pixels [$];
    int   mismatch_count = 0;
    int   hold_off_left  = 0;
    bit   no_idle        = 1'b0;

    layer_pixel_compositor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always #5 clk = ~clk;

    function automatic out_t blend_pixel(in_t b);
        int unsigned acc [3];
        int unsigned px [3];
        int unsigned sep [3];
        int unsigned a;
        int unsigned l;
        int unsigned v;
        int unsigned res [3];
        out_t r;
        acc[0] = b.acc_red;
        acc[1] = b.acc_green;
        acc[2] = b.acc_blue;
        px[0]  = b.layer_red;
        px[1]  = b.layer_green;
        px[2]  = b.layer_blue;
        if (cur_effect == EFFECT_GRAY)
        begin
            v = (px[0] + px[1] + px[2]) / 3;
            px[0] = v;
            px[1] = v;
            px[2] = v;
        end
        else if (cur_effect == EFFECT_SEPIA)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v = SEPIA_Q12[k][0] * px[0] + SEPIA_Q12[k][1] * px[1]
                  + SEPIA_Q12[k][2] * px[2];
                v = v >> Q12_SHIFT;
                sep[k] = (v > CH_MAX) ? CH_MAX : v;
            end
            px = sep;
        end
        a = (cur_alpha > ALPHA_ONE) ? ALPHA_ONE : cur_alpha;
        for (int k = 0; k < 3; k++)
        begin
            l = tone_lut[px[k]];
            if (cur_blend == BLEND_ALPHA)
                res[k] = ((acc[k] * (ALPHA_ONE - a) + l * a) >> 8) & 8'hFF;
            else if (acc[k] < CH_MAX)
            begin
                v = acc[k] + ((l * a) >> 8);
                res[k] = (v > CH_MAX) ? CH_MAX : v;
            end
            else
                res[k] = CH_MAX;
        end
        r.out_red   = res[0][7:0];
        r.out_green = res[1][7:0];
        r.out_blue  = res[2][7:0];
        return r;
    endfunction

    function automatic logic [7:0] pick_channel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return 8'd0;
        if (roll < 12)
            return CH_MAX;
        return 8'($urandom);
    endfunction

    function automatic in_t random_beat();
        in_t b;
        b.op          = ($urandom_range(99) < 15) ? OP_LUT_WRITE : OP_BLEND;
        b.acc_red     = pick_channel();
        b.acc_green   = pick_channel();
        b.acc_blue    = pick_channel();
        b.layer_red   = pick_channel();
        b.layer_green = pick_channel();
        b.layer_blue  = pick_channel();
        b.table_index = 8'($urandom);
        b.table_value = pick_channel();
        return b;
    endfunction

    function automatic in_t pixel_beat(logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
                                       logic [7:0] lr, logic [7:0] lg, logic [7:0] lb);
        in_t b;
        b = random_beat();
        b.op          = OP_BLEND;
        b.acc_red     = ar;
        b.acc_green   = ag;
        b.acc_blue    = ab;
        b.layer_red   = lr;
        b.layer_green = lg;
        b.layer_blue  = lb;
        return b;
    endfunction

    function automatic in_t lut_beat(logic [7:0] idx, logic [7:0] val);
        in_t b;
        b = random_beat();
        b.op          = OP_LUT_WRITE;
        b.table_index = idx;
        b.table_value = val;
        return b;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_channel(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_beat(in_t b);
        int unsigned gap;
        if (!no_idle && $urandom_range(99) < 4)
        begin
            gap = $urandom_range(3, 1);
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_data  <= b;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        if (b.op == OP_LUT_WRITE)
            tone_lut[b.table_index] = b.table_value;
        else
            expected_pixels.push_back(blend_pixel(b));
    endtask

    task automatic wait_drain();
        src_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_addr <= addr;
        cfg_data <= data;
        cfg_en   <= 1'b1;
        @(posedge clk);
        cfg_en   <= 1'b0;
        case (addr)
            CFG_BLEND_MODE:    cur_blend  = data[0];
            CFG_LAYER_ALPHA:   cur_alpha  = data;
            CFG_EFFECT_SELECT: cur_effect = data[1:0];
            default:           ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            dst_stall <= 1'b1;
            hold_off_left--;
        end
        else
            dst_stall <= !no_idle && ($urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result beat with no pixel outstanding");
            else
            begin
                want = expected_pixels.pop_front();
                check_channel("out_red",   dst_data.out_red,   want.out_red);
                check_channel("out_green", dst_data.out_green, want.out_green);
                check_channel("out_blue",  dst_data.out_blue,  want.out_blue);
            end
        end
    end

    task automatic test_reset_defaults();
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_beat(pixel_beat(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX));
        send_beat(pixel_beat(CH_MAX, 8'd0, 8'h5A, 8'h55, 8'hAA, 8'h0F));
    endtask

    task automatic test_lut_load();
        send_beat(lut_beat(8'd0, CH_MAX));
        send_beat(lut_beat(CH_MAX, 8'd0));
        send_beat(lut_beat(8'h80, 8'h01));
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, 8'd0, CH_MAX, 8'h80));
    endtask

    task automatic test_effects();
        write_reg(CFG_EFFECT_SELECT, {7'd0, EFFECT_GRAY});
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, CH_MAX, CH_MAX, CH_MAX));
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0));
        write_reg(CFG_EFFECT_SELECT, {7'd0, EFFECT_SEPIA});
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, CH_MAX, CH_MAX, CH_MAX));
        send_beat(pixel_beat(8'd0, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30));
        write_reg(CFG_EFFECT_SELECT, {7'd0, EFFECT_SPARE});
        send_beat(pixel_beat(8'd7, 8'd9, 8'd11, 8'd40, 8'd90, 8'd200));
        write_reg(CFG_EFFECT_SELECT, {7'd0, EFFECT_NONE});
    endtask

    task automatic test_blend_extremes();
        write_reg(CFG_LAYER_ALPHA, 9'd0);
        send_beat(pixel_beat(8'd12, CH_MAX, 8'd0, CH_MAX, 8'd0, 8'd99));
        write_reg(CFG_LAYER_ALPHA, 9'd511);
        send_beat(pixel_beat(8'd12, CH_MAX, 8'd0, CH_MAX, 8'd3, 8'd99));
        write_reg(CFG_LAYER_ALPHA, 9'd257);
        send_beat(pixel_beat(8'd200, 8'd1, 8'd100, 8'd50, 8'd60, 8'd70));
        write_reg(CFG_BLEND_MODE, {8'd0, BLEND_ADDITIVE});
        write_reg(CFG_LAYER_ALPHA, ALPHA_ONE);
        send_beat(pixel_beat(CH_MAX, 8'd254, 8'd0, 8'd1, CH_MAX, 8'd128));
        send_beat(pixel_beat(8'd100, 8'd200, CH_MAX, 8'd100, 8'd100, 8'd100));
        write_reg(CFG_LAYER_ALPHA, 9'd1);
        send_beat(pixel_beat(8'd254, 8'd0, 8'd10, CH_MAX, CH_MAX, 8'd200));
        write_reg(CFG_SPARE, 9'h1FF);
        send_beat(pixel_beat(8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10));
    endtask

    task automatic test_random_settings();
        logic [8:0] alpha_picks [7];
        logic [8:0] alpha;
        int         per_phase;
        alpha_picks = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd256, 9'd257, 9'd511};
        for (int phase = 0; phase < 16; phase++)
        begin
            alpha = (phase < 7) ? alpha_picks[phase] : 9'($urandom_range(511));
            write_reg(CFG_BLEND_MODE, {8'($urandom), 1'(phase % 2)});
            write_reg(CFG_LAYER_ALPHA, alpha);
            write_reg(CFG_EFFECT_SELECT, {7'($urandom), 2'((phase / 2) % 4)});
            no_idle   = (phase == 9);
            per_phase = $urandom_range(85, 65);
            for (int n = 0; n < per_phase; n++)
                send_beat(random_beat());
            no_idle = 1'b0;
        end
    endtask

    task automatic test_back_pressure();
        write_reg(CFG_BLEND_MODE, {8'd0, BLEND_ALPHA});
        write_reg(CFG_LAYER_ALPHA, 9'd180);
        write_reg(CFG_EFFECT_SELECT, {7'd0, EFFECT_SEPIA});
        hold_off_left = 200;
        for (int n = 0; n < 60; n++)
            send_beat(random_beat());
        wait_drain();
        for (int n = 0; n < 30; n++)
            send_beat(random_beat());
    endtask

    initial
    begin
        for (int i = 0; i < LUT_DEPTH; i++)
            tone_lut[i] = 8'(i);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_lut_load();
        test_effects();
        test_blend_extremes();
        test_random_settings();
        test_back_pressure();
        wait_drain();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== layer_pixel_compositor.f =====
rtl/core/lpc_pkg.sv
rtl/core/layer_pixel_compositor.sv
rtl/core/lpc_checker.sv
tb/tb_layer_pixel_compositor.sv
